>>> hdl/apr_pkg.sv
// apr_pkg: shared constants, register and item codes, and stage structs
// of the argb to planar resampler
// no dependencies
package apr_pkg;

  // frame and plane limits
  localparam int unsigned MAX_SRC_WIDTH  = 256;
  localparam int unsigned MAX_SRC_HEIGHT = 256;
  localparam int unsigned MAX_DST_DIM    = 1024;
  localparam int unsigned FRAME_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int unsigned ADDR_W         = $clog2(FRAME_DEPTH);
  localparam int unsigned SX_W           = $clog2(MAX_SRC_WIDTH);
  localparam int unsigned SY_W           = $clog2(MAX_SRC_HEIGHT);

  // arithmetic widths
  localparam int unsigned POS_W   = 34;          // col * ratio, Q18.16
  localparam int unsigned COORD_W = POS_W - 15;  // integer part plus neighbor step
  localparam int unsigned WGT_W   = 33;          // product of two Q16 weights
  localparam int unsigned PROD_W  = WGT_W + 8;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned QUO_W   = 24;          // accumulator over 2^16
  localparam int unsigned OFF_W   = 22;

  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(255 * (2 ** 15));
  localparam logic [16:0]      RECIP_255  = 17'd65793;   // 2^24 / 255 truncated
  localparam logic [QUO_W-1:0] DIV_BY     = QUO_W'(255);
  localparam logic [16:0]      ONE_Q16    = 17'h10000;
  localparam logic [17:0]      SAT_MAX    = 18'h0FFFF;

  localparam logic [8:0]  SRC_W_MAX   = 9'(MAX_SRC_WIDTH);
  localparam logic [8:0]  SRC_H_MAX   = 9'(MAX_SRC_HEIGHT);
  localparam logic [10:0] DST_DIM_MAX = 11'(MAX_DST_DIM);

  // item codes
  localparam logic       OP_STORE  = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;
  localparam logic [1:0] CH_PLANE0 = 2'd0;
  localparam logic [1:0] CH_PLANE1 = 2'd1;
  localparam logic [1:0] CH_PLANE2 = 2'd2;
  localparam logic [1:0] CH_NONE   = 2'd3;
  localparam logic [1:0] BEAT_LAST = 2'd3;
  localparam logic       MODE_BILINEAR = 1'b1;

  // register indexes
  localparam logic [2:0] REG_SRC_WIDTH    = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH    = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT   = 3'd3;
  localparam logic [2:0] REG_WIDTH_RATIO  = 3'd4;
  localparam logic [2:0] REG_HEIGHT_RATIO = 3'd5;
  localparam logic [2:0] REG_INTERP_MODE  = 3'd6;

  // clamped configuration
  typedef struct packed {
    logic [8:0]  src_w;
    logic [8:0]  src_h;
    logic [10:0] dst_w;
    logic [10:0] dst_h;
    logic [23:0] w_ratio;
    logic [23:0] h_ratio;
    logic        bilinear;
  } cfg_t;

  // one frame access: a store or one neighbor read of a sample
  typedef struct packed {
    logic              vld;
    logic              store;
    logic              first;
    logic              last;
    logic              in_frame;
    logic [SX_W-1:0]   nx;
    logic [SY_W-1:0]   ny;
    logic [WGT_W-1:0]  weight;
    logic [1:0]        channel;
    logic [OFF_W-1:0]  offset;
    logic [ADDR_W-1:0] index;
    logic [31:0]       pixel;
  } mreq_t;

  // one neighbor read returned from the frame
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic             in_frame;
    logic [WGT_W-1:0] weight;
    logic [1:0]       channel;
    logic [OFF_W-1:0] offset;
    logic [31:0]      rdata;
  } mrsp_t;

endpackage

>>> hdl/apr_cfg_regs.sv
// apr_cfg_regs: configuration registers with clamping to the frame limits
// depends on apr_pkg
module apr_cfg_regs (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [23:0]         cfg_data_i,
  output apr_pkg::cfg_t       cfg_o
);
  import apr_pkg::*;

  logic [8:0]  src_width_q, src_height_q;
  logic [10:0] dst_width_q, dst_height_q;
  logic [23:0] width_ratio_q, height_ratio_q;
  logic        interp_q;

  assign cfg_ready_o = 1'b1;

  // register writes, unknown index ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q    <= 9'd256;
      src_height_q   <= 9'd256;
      dst_width_q    <= 11'd256;
      dst_height_q   <= 11'd256;
      width_ratio_q  <= 24'd65536;
      height_ratio_q <= 24'd65536;
      interp_q       <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_WIDTH:    src_width_q    <= cfg_data_i[8:0];
        REG_SRC_HEIGHT:   src_height_q   <= cfg_data_i[8:0];
        REG_DST_WIDTH:    dst_width_q    <= cfg_data_i[10:0];
        REG_DST_HEIGHT:   dst_height_q   <= cfg_data_i[10:0];
        REG_WIDTH_RATIO:  width_ratio_q  <= cfg_data_i;
        REG_HEIGHT_RATIO: height_ratio_q <= cfg_data_i;
        REG_INTERP_MODE:  interp_q       <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp dimensions to the limits
  always_comb begin
    cfg_o.src_w    = (src_width_q > SRC_W_MAX) ? SRC_W_MAX : src_width_q;
    cfg_o.src_h    = (src_height_q > SRC_H_MAX) ? SRC_H_MAX : src_height_q;
    cfg_o.dst_w    = (dst_width_q > DST_DIM_MAX) ? DST_DIM_MAX : dst_width_q;
    cfg_o.dst_h    = (dst_height_q > DST_DIM_MAX) ? DST_DIM_MAX : dst_height_q;
    cfg_o.w_ratio  = width_ratio_q;
    cfg_o.h_ratio  = height_ratio_q;
    cfg_o.bilinear = (interp_q == MODE_BILINEAR);
  end

endmodule

>>> hdl/apr_addr_gen.sv
// apr_addr_gen: item intake, neighbor beat sequencer, source position,
// bilinear weights and planar offset; feeds one frame access per cycle
// depends on apr_pkg
module apr_addr_gen (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          op_i,
  input  logic [15:0]   load_index_i,
  input  logic [31:0]   pixel_i,
  input  logic [9:0]    dst_col_i,
  input  logic [9:0]    dst_row_i,
  input  logic [1:0]    channel_i,
  input  apr_pkg::cfg_t cfg_i,
  output apr_pkg::mreq_t mreq_o
);
  import apr_pkg::*;

  logic        accept;

  // beat stage
  logic        s0_vld_q;
  logic [1:0]  beat_q;
  logic        s0_bil_q, s0_store_q;
  logic [9:0]  s0_col_q, s0_row_q;
  logic [1:0]  s0_ch_q;
  logic [15:0] s0_index_q;
  logic [31:0] s0_pixel_q;

  // position stage
  logic             s1_vld_q;
  logic [POS_W-1:0] s1_sx_q, s1_sy_q;
  logic [21:0]      s1_plane_q;
  logic [20:0]      s1_rowoff_q;
  logic             s1_store_q, s1_first_q, s1_last_q, s1_bx_q, s1_by_q, s1_bil_q;
  logic [1:0]       s1_ch_q;
  logic [9:0]       s1_col_q;
  logic [15:0]      s1_index_q;
  logic [31:0]      s1_pixel_q;

  // neighbor stage signals
  logic [15:0]        dx, dy;
  logic [16:0]        wx, wy;
  logic [COORD_W-1:0] nx, ny;
  logic               in_frame;
  logic [22:0]        plane_sel;
  logic [OFF_W-1:0]   offset;
  mreq_t              mreq_q;

  // a bilinear sample holds the intake until the last of its four neighbor beats
  assign busy   = s0_vld_q & s0_bil_q & (beat_q != BEAT_LAST);
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      beat_q   <= '0;
    end else if (accept) begin
      s0_vld_q <= (op_i == OP_STORE) || (channel_i != CH_NONE);
      beat_q   <= '0;
    end else if (busy) begin
      beat_q <= beat_q + 2'd1;
    end else begin
      s0_vld_q <= 1'b0;
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_store_q <= (op_i == OP_STORE);
      s0_bil_q   <= (op_i == OP_SAMPLE) && cfg_i.bilinear;
      s0_col_q   <= dst_col_i;
      s0_row_q   <= dst_row_i;
      s0_ch_q    <= channel_i;
      s0_index_q <= load_index_i;
      s0_pixel_q <= pixel_i;
    end
  end

  // source position and plane products
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_sx_q     <= POS_W'(s0_col_q) * POS_W'(cfg_i.w_ratio);
    s1_sy_q     <= POS_W'(s0_row_q) * POS_W'(cfg_i.h_ratio);
    s1_plane_q  <= 22'(cfg_i.dst_w) * 22'(cfg_i.dst_h);
    s1_rowoff_q <= 21'(s0_row_q) * 21'(cfg_i.dst_w);
    s1_store_q  <= s0_store_q;
    s1_first_q  <= (beat_q == '0);
    s1_last_q   <= ~s0_bil_q | (beat_q == BEAT_LAST);
    s1_bx_q     <= beat_q[1];
    s1_by_q     <= beat_q[0];
    s1_bil_q    <= s0_bil_q;
    s1_ch_q     <= s0_ch_q;
    s1_col_q    <= s0_col_q;
    s1_index_q  <= s0_index_q;
    s1_pixel_q  <= s0_pixel_q;
  end

  // neighbor coordinates, nearest mode drops the fraction
  always_comb begin
    dx       = s1_bil_q ? s1_sx_q[15:0] : 16'd0;
    dy       = s1_bil_q ? s1_sy_q[15:0] : 16'd0;
    wx       = s1_bx_q ? {1'b0, dx} : ONE_Q16 - {1'b0, dx};
    wy       = s1_by_q ? {1'b0, dy} : ONE_Q16 - {1'b0, dy};
    nx       = COORD_W'(s1_sx_q[POS_W-1:16]) + COORD_W'(s1_bx_q);
    ny       = COORD_W'(s1_sy_q[POS_W-1:16]) + COORD_W'(s1_by_q);
    in_frame = (nx < COORD_W'(cfg_i.src_w)) && (ny < COORD_W'(cfg_i.src_h));
  end

  // planar offset, wraps at the port width
  always_comb begin
    case (s1_ch_q)
      CH_PLANE1: plane_sel = 23'(s1_plane_q);
      CH_PLANE2: plane_sel = {s1_plane_q, 1'b0};
      default:   plane_sel = '0;
    endcase
    offset = OFF_W'(plane_sel + 23'(s1_rowoff_q) + 23'(s1_col_q));
  end

  // frame access register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mreq_q <= '0;
    end else begin
      mreq_q.vld      <= s1_vld_q;
      mreq_q.store    <= s1_store_q;
      mreq_q.first    <= s1_first_q;
      mreq_q.last     <= s1_last_q;
      mreq_q.in_frame <= in_frame;
      mreq_q.nx       <= nx[SX_W-1:0];
      mreq_q.ny       <= ny[SY_W-1:0];
      mreq_q.weight   <= WGT_W'(34'(wx) * 34'(wy));
      mreq_q.channel  <= s1_ch_q;
      mreq_q.offset   <= offset;
      mreq_q.index    <= ADDR_W'(s1_index_q);
      mreq_q.pixel    <= s1_pixel_q;
    end
  end

  assign mreq_o = mreq_q;

endmodule

>>> hdl/apr_frame_mem.sv
// apr_frame_mem: source frame memory, one store or one neighbor read a cycle
// depends on apr_pkg
module apr_frame_mem (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  apr_pkg::mreq_t mreq_i,
  input  logic [8:0]     src_w_i,
  output apr_pkg::mrsp_t mrsp_o
);
  import apr_pkg::*;

  logic [31:0]       mem [FRAME_DEPTH];
  logic [ADDR_W-1:0] rd_addr;
  logic [31:0]       rdata_q;
  logic              vld_q;
  logic              first_q, last_q, in_frame_q;
  logic [WGT_W-1:0]  weight_q;
  logic [1:0]        ch_q;
  logic [OFF_W-1:0]  off_q;

  // row-major address, only meaningful for neighbors inside the frame
  assign rd_addr = ADDR_W'((ADDR_W + 1)'(mreq_i.ny) * (ADDR_W + 1)'(src_w_i)
                   + (ADDR_W + 1)'(mreq_i.nx));

  // stores and reads share the single port in item order, so a read
  // always sees every earlier store
  always_ff @(posedge clk_i) begin
    if (mreq_i.vld && mreq_i.store) begin
      mem[mreq_i.index] <= mreq_i.pixel;
    end
    if (mreq_i.vld && !mreq_i.store) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= mreq_i.vld & ~mreq_i.store;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q    <= mreq_i.first;
    last_q     <= mreq_i.last;
    in_frame_q <= mreq_i.in_frame;
    weight_q   <= mreq_i.weight;
    ch_q       <= mreq_i.channel;
    off_q      <= mreq_i.offset;
  end

  always_comb begin
    mrsp_o.vld      = vld_q;
    mrsp_o.first    = first_q;
    mrsp_o.last     = last_q;
    mrsp_o.in_frame = in_frame_q;
    mrsp_o.weight   = weight_q;
    mrsp_o.channel  = ch_q;
    mrsp_o.offset   = off_q;
    mrsp_o.rdata    = rdata_q;
  end

endmodule

>>> hdl/apr_accum_norm.sv
// apr_accum_norm: byte select, weighted accumulation over the neighbor
// beats and rounding division by 255 * 2^16 with saturation
// depends on apr_pkg
module apr_accum_norm (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  apr_pkg::mrsp_t   mrsp_i,
  output logic             valid_o,
  output logic [15:0]      sample_value_o,
  output logic [21:0]      dst_offset_o
);
  import apr_pkg::*;

  logic [7:0]        byte_sel, pix;

  logic              p_vld_q, p_first_q, p_last_q;
  logic [PROD_W-1:0] prod_q;
  logic [OFF_W-1:0]  p_off_q;

  logic [ACC_W-1:0]  acc_q;
  logic              fin_q;
  logic [OFF_W-1:0]  a_off_q;

  logic [QUO_W-1:0]  t_q;
  logic [16:0]       q0_q;
  logic              n_vld_q;
  logic [OFF_W-1:0]  n_off_q;
  logic [QUO_W+16:0] recip_prod;

  logic [QUO_W:0]    q0x255;
  logic [QUO_W-1:0]  rem;
  logic [17:0]       quo;

  logic              out_vld_q;
  logic [15:0]       out_val_q;
  logic [OFF_W-1:0]  out_off_q;

  // channel picks source byte two minus channel, outside neighbors read zero
  always_comb begin
    case (mrsp_i.channel)
      CH_PLANE0: byte_sel = mrsp_i.rdata[23:16];
      CH_PLANE1: byte_sel = mrsp_i.rdata[15:8];
      default:   byte_sel = mrsp_i.rdata[7:0];
    endcase
    pix = mrsp_i.in_frame ? byte_sel : 8'd0;
  end

  // weighted neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= mrsp_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    p_first_q <= mrsp_i.first;
    p_last_q  <= mrsp_i.last;
    prod_q    <= PROD_W'(mrsp_i.weight) * PROD_W'(pix);
    p_off_q   <= mrsp_i.offset;
  end

  // accumulate, seeded with the rounding bias on the first beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q <= 1'b0;
    end else begin
      fin_q <= p_vld_q & p_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_vld_q) begin
      acc_q <= ACC_W'((p_first_q ? ROUND_BIAS : acc_q) + ACC_W'(prod_q));
    end
    a_off_q <= p_off_q;
  end

  // quotient estimate by reciprocal, low by at most one
  assign recip_prod = (QUO_W + 17)'(acc_q[ACC_W-1:16]) * (QUO_W + 17)'(RECIP_255);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_vld_q <= 1'b0;
    end else begin
      n_vld_q <= fin_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q     <= acc_q[ACC_W-1:16];
    q0_q    <= recip_prod[QUO_W+16:QUO_W];
    n_off_q <= a_off_q;
  end

  // correction step and saturation
  always_comb begin
    q0x255 = {q0_q, 8'd0} - (QUO_W + 1)'(q0_q);
    rem    = QUO_W'((QUO_W + 1)'(t_q) - q0x255);
    quo    = 18'(q0_q) + 18'(rem >= DIV_BY);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= n_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    out_val_q <= (quo > SAT_MAX) ? 16'hFFFF : quo[15:0];
    out_off_q <= n_off_q;
  end

  assign valid_o        = out_vld_q;
  assign sample_value_o = out_val_q;
  assign dst_offset_o   = out_off_q;

endmodule

>>> hdl/argb_to_planar_resampler.sv
// argb_to_planar_resampler: top level of the planar resampler
// depends on apr_pkg, apr_cfg_regs, apr_addr_gen, apr_frame_mem, apr_accum_norm
//
// Usage:
//   Items enter on start while busy is low. A store item (op 0) writes one
//   packed pixel at load_index; a sample item (op 1) returns one result on
//   valid_o, sample_value_o and dst_offset_o for exactly one cycle. A sample
//   with channel 3 is taken and dropped without a result.
//   Configuration writes go on cfg_valid_i / cfg_index_i / cfg_data_i;
//   cfg_ready_o is always high. Write it only while no item is in flight.
//   A new store or nearest sample can be taken while earlier items are still
//   in the pipeline; a bilinear sample makes four neighbor reads in turn on
//   the single frame memory port, and busy is high until its last read.
//   Results leave in item order.
//   The receiver cannot hold off results, so the pipeline never stalls.
//   Reset returns the registers to their defaults and empties the pipeline;
//   the frame memory is not cleared and holds garbage until written.
module argb_to_planar_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [15:0] load_index_i,
  input  logic [31:0] pixel_i,
  input  logic [9:0]  dst_col_i,
  input  logic [9:0]  dst_row_i,
  input  logic [1:0]  channel_i,
  output logic        valid_o,
  output logic [15:0] sample_value_o,
  output logic [21:0] dst_offset_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);
  import apr_pkg::*;

  cfg_t  cfg;
  mreq_t mreq;
  mrsp_t mrsp;

  // configuration registers
  apr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // intake and neighbor sequencing
  apr_addr_gen u_addr (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .op_i         (op_i),
    .load_index_i (load_index_i),
    .pixel_i      (pixel_i),
    .dst_col_i    (dst_col_i),
    .dst_row_i    (dst_row_i),
    .channel_i    (channel_i),
    .cfg_i        (cfg),
    .mreq_o       (mreq)
  );

  // source frame
  apr_frame_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mreq_i  (mreq),
    .src_w_i (cfg.src_w),
    .mrsp_o  (mrsp)
  );

  // accumulation and normalization
  apr_accum_norm u_norm (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mrsp_i         (mrsp),
    .valid_o        (valid_o),
    .sample_value_o (sample_value_o),
    .dst_offset_o   (dst_offset_o)
  );

endmodule

>>> sim/apr_sample_checker.sv
`timescale 1ns / 100ps
// apr_sample_checker: watches the item, result and register channels of the
// planar resampler, predicts each sample and compares; depends on apr_pkg
module apr_sample_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic        op_i,
  input  logic [15:0] load_index_i,
  input  logic [31:0] pixel_i,
  input  logic [9:0]  dst_col_i,
  input  logic [9:0]  dst_row_i,
  input  logic [1:0]  channel_i,
  input  logic        valid_o,
  input  logic [15:0] sample_value_o,
  input  logic [21:0] dst_offset_o,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  output int          pending_o,
  output int          mismatches_o
);
  import apr_pkg::*;

  typedef struct packed {
    logic [15:0] value;
    logic [21:0] offset;
  } sample_t;

  // src 256x256, plane 256x256, unit steps, nearest
  localparam cfg_t CFG_AT_RESET = {9'd256, 9'd256, 11'd256, 11'd256,
                                   24'h010000, 24'h010000, 1'b0};
  localparam logic [63:0] NORM_DIV  = 64'd255 << 16;
  localparam logic [63:0] NORM_HALF = 64'd255 << 15;
  localparam int          PRINT_CAP = 40;

  cfg_t        cfg_q;
  logic [31:0] frame_q [FRAME_DEPTH];
  sample_t     awaited_samples [$];
  sample_t     oldest;
  int          mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // one channel byte of a source neighbor, zero outside the frame
  function automatic logic [63:0] frame_byte(logic [63:0] x, logic [63:0] y,
                                             logic [1:0] ch);
    logic [63:0] fw, fh;
    logic [31:0] word;
    fw = (cfg_q.src_w > SRC_W_MAX) ? 64'(SRC_W_MAX) : 64'(cfg_q.src_w);
    fh = (cfg_q.src_h > SRC_H_MAX) ? 64'(SRC_H_MAX) : 64'(cfg_q.src_h);
    if (x >= fw || y >= fh) return 64'd0;
    word = frame_q[ADDR_W'(y * fw + x)];
    case (ch)
      CH_PLANE0: return 64'(word[23:16]);
      CH_PLANE1: return 64'(word[15:8]);
      default:   return 64'(word[7:0]);
    endcase
  endfunction

  // normalized value and planar offset of one destination sample
  function automatic sample_t resample_point(logic [9:0] col, logic [9:0] row,
                                             logic [1:0] ch);
    logic [63:0] sx, sy, ix, iy, dx, dy, ex, ey, acc, quo, dw, dh;
    sample_t r;
    sx = 64'(col) * 64'(cfg_q.w_ratio);
    sy = 64'(row) * 64'(cfg_q.h_ratio);
    ix = sx >> 16;
    iy = sy >> 16;
    dx = 64'(sx[15:0]);
    dy = 64'(sy[15:0]);
    ex = 64'(ONE_Q16) - dx;
    ey = 64'(ONE_Q16) - dy;
    if (cfg_q.bilinear == MODE_BILINEAR) begin
      acc = ey * ex * frame_byte(ix, iy, ch)
          + dy * ex * frame_byte(ix, iy + 64'd1, ch)
          + ey * dx * frame_byte(ix + 64'd1, iy, ch)
          + dy * dx * frame_byte(ix + 64'd1, iy + 64'd1, ch);
    end else begin
      acc = frame_byte(ix, iy, ch) << 32;
    end
    // divide by 255 in Q16, round half up, saturate
    quo = (acc + NORM_HALF) / NORM_DIV;
    r.value = (quo > 64'hFFFF) ? 16'hFFFF : quo[15:0];
    dw = (cfg_q.dst_w > DST_DIM_MAX) ? 64'(DST_DIM_MAX) : 64'(cfg_q.dst_w);
    dh = (cfg_q.dst_h > DST_DIM_MAX) ? 64'(DST_DIM_MAX) : 64'(cfg_q.dst_h);
    r.offset = OFF_W'(64'(ch) * dw * dh + 64'(row) * dw + 64'(col));
    return r;
  endfunction

  task automatic report_mismatch(string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] sample mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = CFG_AT_RESET;
      awaited_samples.delete();
      pending_o <= 0;
    end else begin
      // a result goes against the oldest awaited sample
      if (valid_o) begin
        if (awaited_samples.size() == 0) begin
          report_mismatch($sformatf("result value %h offset %h with nothing awaited",
                                    sample_value_o, dst_offset_o));
        end else begin
          oldest = awaited_samples.pop_front();
          if (sample_value_o !== oldest.value) begin
            report_mismatch($sformatf("value %h, predicted %h (offset %h)",
                                      sample_value_o, oldest.value, oldest.offset));
          end
          if (dst_offset_o !== oldest.offset) begin
            report_mismatch($sformatf("offset %h, predicted %h",
                                      dst_offset_o, oldest.offset));
          end
        end
      end
      // an accepted item lands in the frame copy or awaits its result
      if (start && !busy) begin
        if (op_i == OP_STORE) begin
          frame_q[load_index_i] = pixel_i;
        end else if (channel_i != CH_NONE) begin
          awaited_samples.insert(awaited_samples.size(),
                                 resample_point(dst_col_i, dst_row_i, channel_i));
        end
      end
      // register writes, unknown index ignored
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_SRC_WIDTH:    cfg_q.src_w    = cfg_data_i[8:0];
          REG_SRC_HEIGHT:   cfg_q.src_h    = cfg_data_i[8:0];
          REG_DST_WIDTH:    cfg_q.dst_w    = cfg_data_i[10:0];
          REG_DST_HEIGHT:   cfg_q.dst_h    = cfg_data_i[10:0];
          REG_WIDTH_RATIO:  cfg_q.w_ratio  = cfg_data_i;
          REG_HEIGHT_RATIO: cfg_q.h_ratio  = cfg_data_i;
          REG_INTERP_MODE:  cfg_q.bilinear = cfg_data_i[0];
          default: ;
        endcase
      end
      pending_o <= awaited_samples.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// testbench: drives stores, samples and register settings into the planar
// resampler; depends on apr_pkg, argb_to_planar_resampler, apr_sample_checker
module testbench;
  import apr_pkg::*;

  localparam int         ITEM_TARGET   = 1950;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         TIMEOUT_NS    = 5_000_000;
  localparam logic [2:0] REG_UNUSED    = 3'd7;
  localparam logic       MODE_NEAREST  = ~MODE_BILINEAR;
  localparam cfg_t       CFG_AT_RESET  = {9'd256, 9'd256, 11'd256, 11'd256,
                                          24'h010000, 24'h010000, 1'b0};

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        start        = 1'b0;
  logic        op_i         = 1'b0;
  logic [15:0] load_index_i = '0;
  logic [31:0] pixel_i      = '0;
  logic [9:0]  dst_col_i    = '0;
  logic [9:0]  dst_row_i    = '0;
  logic [1:0]  channel_i    = '0;
  logic        cfg_valid_i  = 1'b0;
  logic [2:0]  cfg_index_i  = '0;
  logic [23:0] cfg_data_i   = '0;
  logic        busy;
  logic        valid_o;
  logic [15:0] sample_value_o;
  logic [21:0] dst_offset_o;
  logic        cfg_ready_o;
  int          pending;
  int          mismatches;

  cfg_t cur_cfg = CFG_AT_RESET;
  bit   written_q [FRAME_DEPTH];
  int   items_sent = 0;
  int   burst_left = 0;

  argb_to_planar_resampler DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .load_index_i(load_index_i), .pixel_i(pixel_i),
    .dst_col_i(dst_col_i), .dst_row_i(dst_row_i), .channel_i(channel_i),
    .valid_o(valid_o), .sample_value_o(sample_value_o), .dst_offset_o(dst_offset_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  apr_sample_checker sample_check (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .op_i(op_i), .load_index_i(load_index_i), .pixel_i(pixel_i),
    .dst_col_i(dst_col_i), .dst_row_i(dst_row_i), .channel_i(channel_i),
    .valid_o(valid_o), .sample_value_o(sample_value_o), .dst_offset_o(dst_offset_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i),
    .pending_o(pending), .mismatches_o(mismatches)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // one item, sent in bursts with random gaps in between
  task automatic send_item(logic op, logic [15:0] idx, logic [31:0] pix,
                           logic [9:0] col, logic [9:0] row, logic [1:0] ch);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    start        <= 1'b1;
    op_i         <= op;
    load_index_i <= idx;
    pixel_i      <= pix;
    dst_col_i    <= col;
    dst_row_i    <= row;
    channel_i    <= ch;
    do @(posedge clk_i); while (busy);
    if (!(op == OP_SAMPLE && ch == CH_NONE)) items_sent++;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 32'hFFFFFFFF;
      1:       return 32'h00000000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_store(logic [15:0] idx, logic [31:0] pix);
    send_item(OP_STORE, idx, pix, 10'($urandom), 10'($urandom), 2'($urandom));
    written_q[idx] = 1'b1;
  endtask

  // store every in-frame neighbor of the sample that was never written
  task automatic fill_neighbors(logic [9:0] col, logic [9:0] row);
    logic [63:0] ix, iy, fw, fh, nx, ny;
    ix = (64'(col) * 64'(cur_cfg.w_ratio)) >> 16;
    iy = (64'(row) * 64'(cur_cfg.h_ratio)) >> 16;
    fw = (cur_cfg.src_w > SRC_W_MAX) ? 64'(SRC_W_MAX) : 64'(cur_cfg.src_w);
    fh = (cur_cfg.src_h > SRC_H_MAX) ? 64'(SRC_H_MAX) : 64'(cur_cfg.src_h);
    for (int oy = 0; oy < 2; oy++) begin
      for (int ox = 0; ox < 2; ox++) begin
        nx = ix + 64'(ox);
        ny = iy + 64'(oy);
        if (nx < fw && ny < fh && !written_q[16'(ny * fw + nx)]) begin
          send_store(16'(ny * fw + nx), rand_pixel());
        end
      end
    end
  endtask

  task automatic send_sample(logic [9:0] col, logic [9:0] row, logic [1:0] ch);
    fill_neighbors(col, row);
    send_item(OP_SAMPLE, 16'($urandom), $urandom, col, row, ch);
  endtask

  // hold items back until every result is in and the pipeline has emptied
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] index, logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // new register setting, written only while the block is idle
  task automatic apply_config(cfg_t c, bit with_stray);
    drain();
    reg_write(REG_SRC_WIDTH,    24'(c.src_w));
    reg_write(REG_SRC_HEIGHT,   24'(c.src_h));
    reg_write(REG_DST_WIDTH,    24'(c.dst_w));
    reg_write(REG_DST_HEIGHT,   24'(c.dst_h));
    reg_write(REG_WIDTH_RATIO,  c.w_ratio);
    reg_write(REG_HEIGHT_RATIO, c.h_ratio);
    reg_write(REG_INTERP_MODE,  24'(c.bilinear));
    if (with_stray) reg_write(REG_UNUSED, 24'($urandom));
    cfg_valid_i <= 1'b0;
    cur_cfg = c;
  endtask

  function automatic cfg_t setting(logic [8:0] sw, logic [8:0] sh, logic [10:0] dw,
                                   logic [10:0] dh, logic [23:0] wr, logic [23:0] hr,
                                   logic bl);
    cfg_t c;
    c = {sw, sh, dw, dh, wr, hr, bl};
    return c;
  endfunction

  // source sizes lean small so the frame fills up quickly
  function automatic logic [8:0] pick_src_dim();
    case ($urandom_range(0, 7))
      0:       return 9'd1;
      1:       return SRC_W_MAX;
      2:       return 9'h1FF;
      3, 4, 5: return 9'($urandom_range(1, 12));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic [10:0] pick_dst_dim();
    case ($urandom_range(0, 7))
      0:       return 11'd1;
      1:       return DST_DIM_MAX;
      2:       return 11'h7FF;
      3, 4, 5: return 11'($urandom_range(1, 32));
      default: return 11'($urandom_range(1, 1024));
    endcase
  endfunction

  // mostly a step that spreads the plane over the frame, plus the extremes, a random step and the unit step
  function automatic logic [23:0] pick_ratio(int fw, int pw);
    logic [63:0] fit;
    case ($urandom_range(0, 9))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      3: return 24'h010000;
      default: begin
        fit = (64'(fw) << 16) / 64'(pw) + 64'($urandom_range(0, 1023));
        return (fit > 64'hFFFFFF) ? 24'hFFFFFF : 24'(fit);
      end
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t c;
    int fw, fh, pw, ph;
    c.src_w    = pick_src_dim();
    c.src_h    = pick_src_dim();
    c.dst_w    = pick_dst_dim();
    c.dst_h    = pick_dst_dim();
    c.bilinear = 1'($urandom_range(0, 1));
    fw = (c.src_w > SRC_W_MAX) ? MAX_SRC_WIDTH : int'(c.src_w);
    fh = (c.src_h > SRC_H_MAX) ? MAX_SRC_HEIGHT : int'(c.src_h);
    pw = (c.dst_w > DST_DIM_MAX) ? MAX_DST_DIM : int'(c.dst_w);
    ph = (c.dst_h > DST_DIM_MAX) ? MAX_DST_DIM : int'(c.dst_h);
    c.w_ratio = pick_ratio(fw, pw);
    c.h_ratio = pick_ratio(fh, ph);
    return c;
  endfunction

  // coordinate mostly inside the plane, sometimes anywhere
  function automatic logic [9:0] pick_coord(logic [10:0] dim);
    int span;
    span = (dim > DST_DIM_MAX) ? MAX_DST_DIM : int'(dim);
    case ($urandom_range(0, 9))
      0:       return 10'd0;
      1:       return 10'(span - 1);
      2:       return 10'($urandom_range(0, 1023));
      default: return 10'($urandom_range(0, span - 1));
    endcase
  endfunction

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting, nearest sampling
    send_store(16'h0000, 32'h00FF8001);
    send_sample(10'd0, 10'd0, CH_PLANE0);       // byte 255 saturates
    send_sample(10'd0, 10'd0, CH_PLANE1);
    send_sample(10'd0, 10'd0, CH_PLANE2);
    send_sample(10'd0, 10'd0, CH_NONE);         // taken, no result
    send_store(16'hFFFF, 32'hFFFFFFFF);
    send_store(16'hFFFE, 32'h00000000);
    send_sample(10'd255, 10'd255, CH_PLANE2);
    send_sample(10'd254, 10'd255, CH_PLANE1);
    send_sample(10'd1023, 10'd1023, CH_PLANE0); // far outside the frame

    // oversized registers, largest steps, bilinear, unknown register index
    apply_config(setting(9'h1FF, 9'h1FF, 11'h7FF, 11'h7FF, 24'hFFFFFF, 24'hFFFFFF,
                         MODE_BILINEAR), 1'b1);
    send_sample(10'd1, 10'd1, CH_PLANE0);
    send_sample(10'd1023, 10'd1023, CH_PLANE2); // largest offset
    send_sample(10'd0, 10'd0, CH_PLANE1);

    // zero frame width reads all zero, zero steps, single-sample plane
    apply_config(setting(9'd0, 9'd4, 11'd1, 11'd1, 24'd0, 24'd0, MODE_BILINEAR), 1'b0);
    send_sample(10'd5, 10'd7, CH_PLANE1);
    send_sample(10'd0, 10'd0, CH_PLANE2);

    // half steps over a small frame, right and bottom neighbors of edge samples fall outside
    apply_config(setting(9'd4, 9'd3, 11'd8, 11'd6, 24'h008000, 24'h008000,
                         MODE_BILINEAR), 1'b0);
    send_sample(10'd0, 10'd0, CH_PLANE0);
    send_sample(10'd3, 10'd1, CH_PLANE2);
    send_sample(10'd7, 10'd5, CH_PLANE1);
    send_sample(10'd9, 10'd2, CH_PLANE0);       // past the plane width

    // same frame, nearest, back to the smallest plane
    apply_config(setting(9'd4, 9'd3, 11'd1, 11'd1, 24'h018000, 24'h00C000,
                         MODE_NEAREST), 1'b0);
    send_sample(10'd2, 10'd3, CH_PLANE2);

    // random phases: one setting each, samples with their neighbors filled in
    while (items_sent < ITEM_TARGET) begin
      apply_config(random_setting(), $urandom_range(0, 7) == 0);
      repeat ($urandom_range(80, 240)) begin
        if (items_sent >= ITEM_TARGET) break;
        case ($urandom_range(0, 19))
          0, 1, 2: send_store(16'($urandom), rand_pixel());
          3:       send_sample(pick_coord(cur_cfg.dst_w), pick_coord(cur_cfg.dst_h),
                               CH_NONE);
          default: send_sample(pick_coord(cur_cfg.dst_w), pick_coord(cur_cfg.dst_h),
                               2'($urandom_range(0, 2)));
        endcase
        if ($urandom_range(0, 149) == 0) drain();
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/apr_pkg.sv
hdl/apr_cfg_regs.sv
hdl/apr_addr_gen.sv
hdl/apr_frame_mem.sv
hdl/apr_accum_norm.sv
hdl/argb_to_planar_resampler.sv
sim/apr_sample_checker.sv
sim/testbench.sv
